// ===== rtl/window3x3_rank_mean_filter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 rank and mean filter
// Concurrent checks sampled on clk_i, off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef WINDOW3X3_RANK_MEAN_FILTER_CORE_ASSERT_SVH
`define WINDOW3X3_RANK_MEAN_FILTER_CORE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds at the same edge.
`define RMF3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define RMF3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rmf3_pkg.sv =====
// ----------------------------------------------------------------------------
// rmf3_pkg
// Shared types and codes for the 3x3 rank and mean filter.
// ----------------------------------------------------------------------------
package rmf3_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned RowW     = 12;
  localparam int unsigned OutColW  = 10;
  localparam int unsigned GeoW     = 13;   // widest geometry register
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned MinSize  = 3;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFilterMode  = 2'd2;

  // filter mode codes
  localparam logic [1:0] ModeMedian = 2'd0;
  localparam logic [1:0] ModeMin    = 2'd1;
  localparam logic [1:0] ModeMax    = 2'd2;
  localparam logic [1:0] ModeMean   = 2'd3;

  // position tag that travels with each pixel through the pipeline
  typedef struct packed {
    logic [RowW-1:0]    row;   // centre row (pixel row - 1)
    logic [OutColW-1:0] col;   // centre column (pixel column - 1)
    logic               last;  // last interior result of the frame
    logic               emit;  // window is centred on an interior position
  } meta_t;

endpackage

// ===== rtl/rmf3_linebuf.sv =====
// ----------------------------------------------------------------------------
// rmf3_linebuf
// Two line stores, one row each; registered read, write one stage later.
// ----------------------------------------------------------------------------
module rmf3_linebuf #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr_i,
  output logic [rmf3_pkg::PixW-1:0]     upper_q_o,
  output logic [rmf3_pkg::PixW-1:0]     middle_q_o,
  input  logic                          wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr_i,
  input  logic [rmf3_pkg::PixW-1:0]     wr_upper_i,
  input  logic [rmf3_pkg::PixW-1:0]     wr_middle_i
);

  logic [rmf3_pkg::PixW-1:0] upper_mem  [MAX_WIDTH];
  logic [rmf3_pkg::PixW-1:0] middle_mem [MAX_WIDTH];
  logic [rmf3_pkg::PixW-1:0] upper_q;
  logic [rmf3_pkg::PixW-1:0] middle_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i] <= wr_upper_i;
    end
    if (rd_en_i) begin
      upper_q <= upper_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      middle_mem[wr_addr_i] <= wr_middle_i;
    end
    if (rd_en_i) begin
      middle_q <= middle_mem[rd_addr_i];
    end
  end

  assign upper_q_o  = upper_q;
  assign middle_q_o = middle_q;

endmodule

// ===== rtl/rmf3_kernel.sv =====
// ----------------------------------------------------------------------------
// rmf3_kernel
// 3x3 window register and the rank / mean network feeding the result register.
// ----------------------------------------------------------------------------
module rmf3_kernel (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic                           in_valid_i,
  input  rmf3_pkg::meta_t                meta_i,
  input  logic [rmf3_pkg::PixW-1:0]      pixel_i,
  input  logic [rmf3_pkg::PixW-1:0]      upper_i,
  input  logic [rmf3_pkg::PixW-1:0]      middle_i,
  input  logic [1:0]                     mode_i,
  output logic                           out_valid_o,
  output logic [rmf3_pkg::RowW-1:0]      out_row_o,
  output logic [rmf3_pkg::OutColW-1:0]   out_col_o,
  output logic [rmf3_pkg::PixW-1:0]      out_pix_o,
  output logic                           out_last_o
);

  typedef logic [8:0][rmf3_pkg::PixW-1:0] win_t;

  // Nine-input median, 19 compare-exchange cells.
  function automatic logic [rmf3_pkg::PixW-1:0] med9(input win_t w);
    win_t p;
    logic [rmf3_pkg::PixW-1:0] t;
    p = w;
    if (p[1] > p[2]) begin t = p[1]; p[1] = p[2]; p[2] = t; end
    if (p[4] > p[5]) begin t = p[4]; p[4] = p[5]; p[5] = t; end
    if (p[7] > p[8]) begin t = p[7]; p[7] = p[8]; p[8] = t; end
    if (p[0] > p[1]) begin t = p[0]; p[0] = p[1]; p[1] = t; end
    if (p[3] > p[4]) begin t = p[3]; p[3] = p[4]; p[4] = t; end
    if (p[6] > p[7]) begin t = p[6]; p[6] = p[7]; p[7] = t; end
    if (p[1] > p[2]) begin t = p[1]; p[1] = p[2]; p[2] = t; end
    if (p[4] > p[5]) begin t = p[4]; p[4] = p[5]; p[5] = t; end
    if (p[7] > p[8]) begin t = p[7]; p[7] = p[8]; p[8] = t; end
    if (p[0] > p[3]) p[3] = p[0];
    if (p[8] < p[5]) p[5] = p[8];
    if (p[4] > p[7]) begin t = p[4]; p[4] = p[7]; p[7] = t; end
    if (p[3] > p[6]) p[6] = p[3];
    if (p[1] > p[4]) p[4] = p[1];
    if (p[5] < p[2]) p[2] = p[5];
    if (p[7] < p[4]) p[4] = p[7];
    if (p[4] > p[2]) begin t = p[4]; p[4] = p[2]; p[2] = t; end
    if (p[6] > p[4]) p[4] = p[6];
    if (p[2] < p[4]) p[4] = p[2];
    return p[4];
  endfunction

  win_t                            win_q;
  logic                            s2_valid_q;
  rmf3_pkg::meta_t                 s2_meta_q;
  logic                            out_valid_q;
  logic [rmf3_pkg::RowW-1:0]       out_row_q;
  logic [rmf3_pkg::OutColW-1:0]    out_col_q;
  logic [rmf3_pkg::PixW-1:0]       out_pix_q;
  logic                            out_last_q;

  logic [rmf3_pkg::PixW-1:0]       min_v;
  logic [rmf3_pkg::PixW-1:0]       max_v;
  logic [11:0]                     sum_v;
  logic [25:0]                     quot_v;
  logic [rmf3_pkg::PixW-1:0]       res_d;

  // shift window: column 2 takes the new column (upper, middle, current row)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= in_valid_i && meta_i.emit;
      if (in_valid_i) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= upper_i;
        win_q[3] <= win_q[4];
        win_q[4] <= win_q[5];
        win_q[5] <= middle_i;
        win_q[6] <= win_q[7];
        win_q[7] <= win_q[8];
        win_q[8] <= pixel_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_meta_q <= meta_i;
    end
  end

  always_comb begin
    min_v = win_q[0];
    max_v = win_q[0];
    sum_v = 12'(win_q[0]);
    for (int i = 1; i < 9; i++) begin
      if (win_q[i] < min_v) min_v = win_q[i];
      if (win_q[i] > max_v) max_v = win_q[i];
      sum_v = sum_v + 12'(win_q[i]);
    end
    // divide by nine: reciprocal 7282 / 2^16 is exact for sums up to 2295
    quot_v = 26'(sum_v) * 26'd7282;
    case (mode_i)
      rmf3_pkg::ModeMedian: res_d = med9(win_q);
      rmf3_pkg::ModeMin:    res_d = min_v;
      rmf3_pkg::ModeMax:    res_d = max_v;
      rmf3_pkg::ModeMean:   res_d = quot_v[23:16];
      default:              res_d = med9(win_q);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_row_q  <= s2_meta_q.row;
      out_col_q  <= s2_meta_q.col;
      out_pix_q  <= res_d;
      out_last_q <= s2_meta_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_pix_o   = out_pix_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/window3x3_rank_mean_filter_core.sv =====
// ----------------------------------------------------------------------------
// window3x3_rank_mean_filter_core
// Streaming 3x3 median / minimum / maximum / mean filter over 8-bit gray
// pixels in raster order; one result per interior pixel position.
//
//  Channel     | Direction | Transaction carries
//  ------------+-----------+-----------------------------------------------
//  s_axis      | in        | one pixel, tdata[7:0]
//  m_axis      | out       | row, column, filtered value; tlast = frame end
//  cfg         | in        | register write: width, height or filter mode
//
// One pixel per clock while m_axis_tready is high; three register stages
// (input with line-store read, window, result) lie between the acceptance of
// the pixel completing a window and the presentation of its result.
// Reset clears counters, window and valid flags; line stores are not cleared
// and are never read into a result before being written.
// A stalled m_axis holds every stage and drops s_axis_tready with it.
// ----------------------------------------------------------------------------
`include "window3x3_rank_mean_filter_core_assert.svh"

module window3x3_rank_mean_filter_core #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // pixel input
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,   // [7:0] pixel
  // filtered output
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [11:0] out_row, [21:12] out_col, [29:22] filtered, [31:30] zero
  output logic [31:0]                          m_axis_tdata,
  output logic                                 m_axis_tlast,   // frame_end
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [rmf3_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [rmf3_pkg::GeoW-1:0]            cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned GW = rmf3_pkg::GeoW;
  localparam logic [GW-1:0] MaxW  = GW'(MAX_WIDTH);
  localparam logic [GW-1:0] MaxH  = GW'(rmf3_pkg::MaxHeight);
  localparam logic [GW-1:0] MinSz = GW'(rmf3_pkg::MinSize);
  localparam logic [GW-1:0] WidthRst  = (MAX_WIDTH < 640) ? GW'(MAX_WIDTH) : GW'(640);
  localparam logic [GW-1:0] HeightRst = GW'(480);

  // effective (already clamped) geometry and mode
  logic [GW-1:0]                w_eff_q, w_eff_d;
  logic [GW-1:0]                h_eff_q, h_eff_d;
  logic [1:0]                   mode_q;
  // position of the next pixel to be accepted
  logic [AW-1:0]                col_q, col_d;
  logic [rmf3_pkg::RowW-1:0]    row_q, row_d;

  logic                         adv;
  logic                         in_fire;
  logic                         col_wrap;
  logic                         row_wrap;
  logic                         geo_write;
  logic [GW-1:0]                wr_w;
  logic [GW-1:0]                wr_h;

  // stage 1: pixel and tag waiting for the line-store read data
  logic                         s1_valid_q;
  logic [7:0]                   s1_pix_q;
  logic [AW-1:0]                s1_col_q;
  rmf3_pkg::meta_t              s1_meta_q, s1_meta_d;

  logic [7:0]                   upper_rd;
  logic [7:0]                   middle_rd;

  logic                         out_valid;
  logic [rmf3_pkg::RowW-1:0]    out_row;
  logic [rmf3_pkg::OutColW-1:0] out_col;
  logic [7:0]                   out_pix;
  logic                         out_last;

  // whole pipeline advances together unless a result is stuck at the output
  assign adv     = !out_valid || m_axis_tready;
  assign in_fire = s_axis_tvalid && adv;

  assign col_wrap = (GW'(col_q) + GW'(1)) >= w_eff_q;
  assign row_wrap = (GW'(row_q) + GW'(1)) >= h_eff_q;

  // clamp geometry on the way in
  always_comb begin
    wr_w = {2'b00, cfg_data_i[10:0]};
    if (wr_w < MinSz) begin
      w_eff_d = MinSz;
    end else if (wr_w > MaxW) begin
      w_eff_d = MaxW;
    end else begin
      w_eff_d = wr_w;
    end
    wr_h = cfg_data_i;
    if (wr_h < MinSz) begin
      h_eff_d = MinSz;
    end else if (wr_h > MaxH) begin
      h_eff_d = MaxH;
    end else begin
      h_eff_d = wr_h;
    end
  end

  assign geo_write = cfg_we_i &&
                     (cfg_idx_i == rmf3_pkg::RegFrameWidth ||
                      cfg_idx_i == rmf3_pkg::RegFrameHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_eff_q <= WidthRst;
      h_eff_q <= HeightRst;
      mode_q  <= rmf3_pkg::ModeMedian;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rmf3_pkg::RegFrameWidth:  w_eff_q <= w_eff_d;
        rmf3_pkg::RegFrameHeight: h_eff_q <= h_eff_d;
        rmf3_pkg::RegFilterMode:  mode_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // advance raster position; wrap at row and frame end, restart on a geometry write
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (geo_write) begin
      col_d = '0;
      row_d = '0;
    end else if (in_fire) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // tag for the window that this pixel completes
  always_comb begin
    s1_meta_d.row  = row_q - 1'b1;
    s1_meta_d.col  = rmf3_pkg::OutColW'(col_q - 1'b1);
    s1_meta_d.emit = (row_q >= rmf3_pkg::RowW'(2)) && (col_q >= AW'(2));
    s1_meta_d.last = row_wrap && col_wrap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q  <= s_axis_tdata;
      s1_col_q  <= col_q;
      s1_meta_q <= s1_meta_d;
    end
  end

  // read both rows at acceptance; push rows down one stage later
  rmf3_linebuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk_i       (clk_i),
    .rd_en_i     (in_fire),
    .rd_addr_i   (col_q),
    .upper_q_o   (upper_rd),
    .middle_q_o  (middle_rd),
    .wr_en_i     (adv && s1_valid_q),
    .wr_addr_i   (s1_col_q),
    .wr_upper_i  (middle_rd),
    .wr_middle_i (s1_pix_q)
  );

  rmf3_kernel u_kernel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (s1_valid_q),
    .meta_i      (s1_meta_q),
    .pixel_i     (s1_pix_q),
    .upper_i     (upper_rd),
    .middle_i    (middle_rd),
    .mode_i      (mode_q),
    .out_valid_o (out_valid),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_pix_o   (out_pix),
    .out_last_o  (out_last)
  );

  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_pix, out_col, out_row};
  assign m_axis_tlast  = out_last;

  // position counters stay inside the programmed frame
  `RMF3_ASSERT_NOW(a_col_in_frame, 1'b1, (GW'(col_q) < w_eff_q), "column beyond frame width")
  `RMF3_ASSERT_NOW(a_row_in_frame, 1'b1, (GW'(row_q) < h_eff_q), "row beyond frame height")
  // last column of a row always wraps to column zero
  `RMF3_ASSERT_NXT(a_col_wraps, (in_fire && col_wrap), (col_q == '0), "column did not wrap")
  // results only ever come from interior rows
  `RMF3_ASSERT_NOW(a_row_interior, m_axis_tvalid, (m_axis_tdata[11:0] != 12'd0), "border row emitted")

endmodule

// ===== test/window3x3_rank_mean_filter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window3x3_rank_mean_filter_core_tb
// Self-checking bench for the streaming 3x3 median / min / max / mean filter.
// A queue-fed driver streams raster pixels, a local window predictor builds
// the expected interior results, and a monitor checks every output
// transaction field by field. Frame geometry and filter mode are rewritten
// between phases while the core is drained; idling is randomised on both
// channels.
// ----------------------------------------------------------------------------
module window3x3_rank_mean_filter_core_tb;

  localparam int unsigned MaxWidth     = 1024;
  localparam int unsigned CycleLimit   = 400000;
  // pipeline depth plus margin for the delayed line-store write-back
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned RandomPixels = 850;
  // field positions inside m_axis_tdata
  localparam int unsigned ColLsb = rmf3_pkg::RowW;
  localparam int unsigned PixLsb = rmf3_pkg::RowW + rmf3_pkg::OutColW;
  // index past the register list; a write there must change nothing
  localparam logic [rmf3_pkg::CfgIdxW-1:0] RegUnmapped = 2'd3;

  typedef enum int unsigned {StyleUniform, StyleBinary, StyleBand} pixel_style_e;

  typedef struct packed {
    logic [rmf3_pkg::RowW-1:0]    row;
    logic [rmf3_pkg::OutColW-1:0] col;
    logic [rmf3_pkg::PixW-1:0]    value;
    logic                         frame_end;
  } filt_result_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata  = '0;   // [7:0] pixel
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [31:0]                  m_axis_tdata;  // [11:0] row, [21:12] col, [29:22] value
  logic                         m_axis_tlast;  // frame end
  logic                         cfg_we_i      = 1'b0;
  logic [rmf3_pkg::CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [rmf3_pkg::GeoW-1:0]    cfg_data_i    = '0;

  logic [rmf3_pkg::PixW-1:0] pixel_q[$];     // pixels waiting for the driver
  filt_result_t              expected_q[$];  // predicted results, oldest first

  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 78;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  // Predictor state: a copy of the register file, line stores and window
  logic [10:0]               width_reg  = 11'd640;
  logic [12:0]               height_reg = 13'd480;
  logic [1:0]                mode_reg   = rmf3_pkg::ModeMedian;
  logic [rmf3_pkg::PixW-1:0] upper_line  [MaxWidth];
  logic [rmf3_pkg::PixW-1:0] middle_line [MaxWidth];
  logic [rmf3_pkg::PixW-1:0] win [9];   // row-major, column 2 newest
  int unsigned               col_pos = 0;
  int unsigned               row_pos = 0;

  window3x3_rank_mean_filter_core #(
    .MAX_WIDTH(MaxWidth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Effective row length: the width register clamped to what the stores hold
  function automatic int unsigned eff_width();
    if (width_reg < rmf3_pkg::MinSize) return rmf3_pkg::MinSize;
    if (width_reg > MaxWidth) return MaxWidth;
    return 32'(width_reg);
  endfunction

  // Rank or mean of the nine window taps under the current mode
  function automatic logic [rmf3_pkg::PixW-1:0] window_value();
    logic [rmf3_pkg::PixW-1:0] sorted [9];
    logic [rmf3_pkg::PixW-1:0] t;
    int unsigned               acc;
    int                        i;
    int                        j;
    acc = 0;
    case (mode_reg)
      rmf3_pkg::ModeMedian: begin
        for (i = 0; i < 9; i++) sorted[i] = win[i];
        for (i = 1; i < 9; i++) begin
          t = sorted[i];
          j = i;
          while (j > 0 && sorted[j-1] > t) begin
            sorted[j] = sorted[j-1];
            j--;
          end
          sorted[j] = t;
        end
        acc = 32'(sorted[4]);
      end
      rmf3_pkg::ModeMin: begin
        acc = 255;
        for (i = 0; i < 9; i++) if (win[i] < acc) acc = 32'(win[i]);
      end
      rmf3_pkg::ModeMax: begin
        for (i = 0; i < 9; i++) if (win[i] > acc) acc = 32'(win[i]);
      end
      rmf3_pkg::ModeMean: begin
        for (i = 0; i < 9; i++) acc += 32'(win[i]);
        acc = acc / 9;
      end
      default: acc = 0;
    endcase
    return acc[rmf3_pkg::PixW-1:0];
  endfunction

  // Advance the window by one accepted pixel; queue a result when the window
  // is centred on an interior position.
  task automatic predict_pixel(input logic [rmf3_pkg::PixW-1:0] px);
    int unsigned               w_eff;
    int unsigned               h_eff;
    int unsigned               idx;
    logic [rmf3_pkg::PixW-1:0] top;
    logic [rmf3_pkg::PixW-1:0] mid;
    filt_result_t              res;
    int                        k;
    w_eff = eff_width();
    h_eff = (height_reg < rmf3_pkg::MinSize) ? rmf3_pkg::MinSize :
            (height_reg > rmf3_pkg::MaxHeight) ? rmf3_pkg::MaxHeight : 32'(height_reg);
    idx   = (col_pos < MaxWidth) ? col_pos : MaxWidth - 1;
    top   = upper_line[idx];
    mid   = middle_line[idx];
    upper_line[idx]  = mid;
    middle_line[idx] = px;
    for (k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    if (row_pos >= 2 && col_pos >= 2) begin
      res.row       = rmf3_pkg::RowW'(row_pos - 1);
      res.col       = rmf3_pkg::OutColW'(col_pos - 1);
      res.value     = window_value();
      res.frame_end = (row_pos == h_eff - 1) && (col_pos == w_eff - 1);
      expected_q    = {expected_q, res};
    end
    if (col_pos + 1 >= w_eff) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h_eff) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // One register write: enable for a single edge, then drop it. Only called
  // while the core is drained, so the predictor may follow at once.
  task automatic write_reg(input logic [rmf3_pkg::CfgIdxW-1:0] idx,
                           input logic [rmf3_pkg::GeoW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      rmf3_pkg::RegFrameWidth: begin
        width_reg = val[10:0];
        col_pos   = 0;
        row_pos   = 0;
      end
      rmf3_pkg::RegFrameHeight: begin
        height_reg = val[12:0];
        col_pos    = 0;
        row_pos    = 0;
      end
      rmf3_pkg::RegFilterMode: mode_reg = val[1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every queued pixel has been sent and every expected result has
  // left, then let any result-free pixels still in the pipeline settle.
  task automatic wait_idle();
    while (pixel_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [rmf3_pkg::PixW-1:0] random_pixel(
      input pixel_style_e style, input logic [rmf3_pkg::PixW-1:0] base);
    case (style)
      StyleUniform: return rmf3_pkg::PixW'($urandom_range(255));
      StyleBinary:  return $urandom_range(1) ? 8'hFF : 8'h00;
      default:      return base ^ rmf3_pkg::PixW'($urandom_range(3));
    endcase
  endfunction

  task automatic push_pixels(input int unsigned n, input pixel_style_e style,
                             input logic [rmf3_pkg::PixW-1:0] base);
    int unsigned i;
    @(negedge clk_i);
    for (i = 0; i < n; i++) pixel_q = {pixel_q, random_pixel(style, base)};
  endtask

  // Driver: when the slot is free, present the next queued pixel or idle at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_pixel(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pixel_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output transaction against the oldest prediction
  always @(posedge clk_i) begin : result_check
    filt_result_t got;
    filt_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.row       = m_axis_tdata[ColLsb-1:0];
        got.col       = m_axis_tdata[PixLsb-1:ColLsb];
        got.value     = m_axis_tdata[PixLsb+rmf3_pkg::PixW-1:PixLsb];
        got.frame_end = m_axis_tlast;
        if (expected_q.size() == 0) begin
          $error("unexpected result: row %0d col %0d value %0d", got.row, got.col,
                 got.value);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.row !== want.row) begin
            $error("out_row: expected %0d, actual %0d", want.row, got.row);
            fail_count++;
          end
          if (got.col !== want.col) begin
            $error("out_col: expected %0d, actual %0d", want.col, got.col);
            fail_count++;
          end
          if (got.value !== want.value) begin
            $error("filtered: expected %0d, actual %0d", want.value, got.value);
            fail_count++;
          end
          if (got.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, actual %0d", want.frame_end,
                   got.frame_end);
            fail_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    logic [rmf3_pkg::PixW-1:0] corner_px [18];
    int unsigned               sent;
    int unsigned               w;
    int unsigned               h;
    int unsigned               n;
    int unsigned               choice;
    int unsigned               i;
    pixel_style_e              style;
    logic [rmf3_pkg::PixW-1:0] base;

    corner_px = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hFE, 8'h7F,
                  8'hFF, 8'h00, 8'h55, 8'hAA, 8'h10, 8'hEF,
                  8'hFF, 8'hFF, 8'h00, 8'h3C, 8'hC3, 8'h7E};
    for (i = 0; i < MaxWidth; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (i = 0; i < 9; i++) win[i] = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A few pixels at the reset geometry: nowhere near an interior position
    push_pixels(4, StyleUniform, 8'h00);
    wait_idle();

    // Directed: a 6x3 frame with extreme values, one operation per result.
    // The mode changes mid-frame and must not restart it.
    write_reg(rmf3_pkg::RegFrameWidth, 13'd6);
    write_reg(rmf3_pkg::RegFrameHeight, 13'd3);
    write_reg(rmf3_pkg::RegFilterMode, rmf3_pkg::GeoW'(rmf3_pkg::ModeMedian));
    write_reg(RegUnmapped, '1);
    @(negedge clk_i);
    for (i = 0; i < 15; i++) pixel_q = {pixel_q, corner_px[i]};
    wait_idle();
    write_reg(rmf3_pkg::RegFilterMode, rmf3_pkg::GeoW'(rmf3_pkg::ModeMin));
    @(negedge clk_i);
    pixel_q = {pixel_q, corner_px[15]};
    wait_idle();
    write_reg(rmf3_pkg::RegFilterMode, rmf3_pkg::GeoW'(rmf3_pkg::ModeMax));
    @(negedge clk_i);
    pixel_q = {pixel_q, corner_px[16]};
    wait_idle();
    write_reg(rmf3_pkg::RegFilterMode, rmf3_pkg::GeoW'(rmf3_pkg::ModeMean));
    @(negedge clk_i);
    pixel_q = {pixel_q, corner_px[17]};   // closes the frame

    // Random phases: small frames, clamped geometry, mid-frame mode changes
    // and plain holds. Idling: sender light and receiver heavy, then the
    // reverse, then none.
    sent = 0;
    while (sent < RandomPixels) begin
      wait_idle();
      if (sent < RandomPixels / 3) begin
        send_idle_pct = 11;
        recv_idle_pct = 78;
      end else if (sent < 2 * RandomPixels / 3) begin
        send_idle_pct = 78;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      choice = $urandom_range(9);
      if (choice < 6) begin
        case ($urandom_range(9))
          0:       w = $urandom_range(2);
          1:       w = $urandom_range(13, 40);
          default: w = $urandom_range(3, 12);
        endcase
        h = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
        write_reg(rmf3_pkg::RegFrameWidth, rmf3_pkg::GeoW'(w));
        write_reg(rmf3_pkg::RegFrameHeight, rmf3_pkg::GeoW'(h));
        write_reg(rmf3_pkg::RegFilterMode, rmf3_pkg::GeoW'($urandom_range(3)));
        if ($urandom_range(4) == 0) write_reg(RegUnmapped, rmf3_pkg::GeoW'($urandom));
      end else if (choice < 8) begin
        write_reg(rmf3_pkg::RegFilterMode, rmf3_pkg::GeoW'($urandom_range(3)));
      end
      // otherwise just resume after the hold
      h = (height_reg < rmf3_pkg::MinSize) ? rmf3_pkg::MinSize : 32'(height_reg);
      if (h > 6) h = 6;
      n = $urandom_range(eff_width(), 2 * eff_width() * h);
      style = pixel_style_e'($urandom_range(2));
      base  = rmf3_pkg::PixW'($urandom_range(255));
      push_pixels(n, style, base);
      sent += n;
    end

    // Widest geometry: width register saturated, a short run in the first row
    wait_idle();
    write_reg(rmf3_pkg::RegFrameWidth, '1);
    write_reg(rmf3_pkg::RegFrameHeight, 13'd3);
    write_reg(rmf3_pkg::RegFilterMode, rmf3_pkg::GeoW'($urandom_range(3)));
    push_pixels(64, StyleUniform, 8'h00);

    // Tallest geometry: height register saturated at a narrow width
    wait_idle();
    write_reg(rmf3_pkg::RegFrameWidth, 13'd5);
    write_reg(rmf3_pkg::RegFrameHeight, '1);
    write_reg(rmf3_pkg::RegFilterMode, rmf3_pkg::GeoW'($urandom_range(3)));
    push_pixels(40, StyleBand, rmf3_pkg::PixW'($urandom_range(255)));

    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
